// ===== design/dnle_pkg.sv =====
// Package for the DNS name label encoder.
// Holds the character constants, the command type passed from the front end
// to the back end, and the back-end state type. Depends on nothing.
package dnle_pkg;

    localparam int LABEL_MAX_DEF = 62;

    localparam logic [7:0] CH_DOT      = 8'h2E;
    localparam logic [7:0] CH_UPPER_A  = 8'h41;
    localparam logic [7:0] CH_UPPER_Z  = 8'h5A;
    localparam logic [7:0] CASE_OFFSET = 8'd32;
    localparam logic [7:0] TERMINATOR  = 8'h00;

    localparam logic KIND_CHAR = 1'b0;
    localparam logic KIND_END  = 1'b1;

    typedef enum logic [1:0] {
        OP_CHAR,
        OP_DOT,
        OP_END
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [7:0] data;
    } cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LEN,
        ST_DATA,
        ST_TERM
    } back_state_t;

endpackage

// ===== design/dnle_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
// Uses no package.
module dnle_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 62,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== design/dnle_front.sv =====
// Front end of the DNS name label encoder: accepts input transfers, lowers
// upper-case letters, classifies each item and queues it in a two-entry FIFO.
// Depends on dnle_pkg.
module dnle_front
    import dnle_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic       s_kind,
    input  logic [7:0] s_character,
    output logic       cmd_valid,
    input  logic       cmd_ready,
    output cmd_t       cmd
);

    cmd_t       q_reg [2];
    logic       head_reg, head_next;
    logic [1:0] count_reg, count_next;
    logic       push, pop;
    logic       tail;
    cmd_t       cmd_in;

    always_comb begin
        cmd_in.data = s_character;
        unique case (s_kind)
            KIND_END: begin
                cmd_in.op = OP_END;
            end
            default: begin
                if (s_character == CH_DOT) begin
                    cmd_in.op = OP_DOT;
                end else begin
                    cmd_in.op = OP_CHAR;
                end
                if (s_character >= CH_UPPER_A && s_character <= CH_UPPER_Z) begin
                    cmd_in.data = s_character + CASE_OFFSET;
                end
            end
        endcase
    end

    assign s_ready   = (count_reg != 2'd2);
    assign cmd_valid = (count_reg != 2'd0);
    assign cmd       = q_reg[head_reg];
    assign push      = s_valid && s_ready;
    assign pop       = cmd_valid && cmd_ready;
    assign tail      = head_reg ^ count_reg[0];

    always_comb begin
        head_next  = head_reg;
        count_next = count_reg;
        if (pop) begin
            head_next = ~head_reg;
        end
        if (push && !pop) begin
            count_next = count_reg + 2'd1;
        end else if (pop && !push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg  <= 1'b0;
            count_reg <= 2'd0;
        end else begin
            head_reg  <= head_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            q_reg[tail] <= cmd_in;
        end
    end

endmodule

// ===== design/dnle_back.sv =====
// Back end of the DNS name label encoder: keeps the pending label in a RAM;
// a dot or end of name sends the length byte and label bytes if non-empty, an
// end of name also the terminator, via an output register. Uses dnle_pkg, dnle_ram.
module dnle_back
    import dnle_pkg::*;
#(
    parameter int LABEL_MAX = LABEL_MAX_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cmd_valid,
    output logic       cmd_ready,
    input  cmd_t       cmd,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_wire_byte,
    output logic       m_name_done,
    output logic       m_label_overflow
);

    localparam int FILL_W = $clog2(LABEL_MAX + 1);
    localparam int ADDR_W = (LABEL_MAX > 1) ? $clog2(LABEL_MAX) : 1;

    back_state_t       state_reg, state_next;
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic [ADDR_W-1:0] idx_reg, idx_next;
    logic              ovf_reg, ovf_next;
    logic              end_reg, end_next;

    logic              out_valid_reg, out_valid_next;
    logic [7:0]        out_byte_reg, out_byte_next;
    logic              out_done_reg, out_done_next;
    logic              out_ovf_reg, out_ovf_next;

    logic              out_free;
    logic              ram_we;
    logic [7:0]        ram_rdata;
    logic              last_byte;

    dnle_ram #(
        .WIDTH (8),
        .DEPTH (LABEL_MAX)
    ) u_label_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (fill_reg[ADDR_W-1:0]),
        .wdata (cmd.data),
        .raddr (idx_next),
        .rdata (ram_rdata)
    );

    assign out_free  = !out_valid_reg || m_ready;
    assign cmd_ready = (state_reg == ST_IDLE);
    assign last_byte = (FILL_W'(idx_reg) + FILL_W'(1)) == fill_reg;

    always_comb begin
        state_next     = state_reg;
        fill_next      = fill_reg;
        idx_next       = idx_reg;
        ovf_next       = ovf_reg;
        end_next       = end_reg;
        out_valid_next = out_valid_reg && !m_ready;
        out_byte_next  = out_byte_reg;
        out_done_next  = out_done_reg;
        out_ovf_next   = out_ovf_reg;
        ram_we         = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                idx_next = '0;
                if (cmd_valid) begin
                    unique case (cmd.op)
                        OP_CHAR: begin
                            if (fill_reg < FILL_W'(LABEL_MAX)) begin
                                ram_we    = 1'b1;
                                fill_next = fill_reg + FILL_W'(1);
                            end else begin
                                ovf_next = 1'b1;
                            end
                        end
                        OP_DOT: begin
                            end_next = 1'b0;
                            if (fill_reg != '0) begin
                                state_next = ST_LEN;
                            end
                        end
                        OP_END: begin
                            end_next = 1'b1;
                            if (fill_reg != '0) begin
                                state_next = ST_LEN;
                            end else begin
                                state_next = ST_TERM;
                            end
                        end
                        default: begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_LEN: begin
                idx_next = '0;
                if (out_free) begin
                    out_valid_next = 1'b1;
                    out_byte_next  = 8'(fill_reg);
                    out_done_next  = 1'b0;
                    out_ovf_next   = ovf_reg;
                    state_next     = ST_DATA;
                end
            end
            ST_DATA: begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    out_byte_next  = ram_rdata;
                    out_done_next  = 1'b0;
                    out_ovf_next   = ovf_reg;
                    if (last_byte) begin
                        idx_next   = '0;
                        fill_next  = '0;
                        state_next = end_reg ? ST_TERM : ST_IDLE;
                    end else begin
                        idx_next = idx_reg + ADDR_W'(1);
                    end
                end
            end
            ST_TERM: begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    out_byte_next  = TERMINATOR;
                    out_done_next  = 1'b1;
                    out_ovf_next   = ovf_reg;
                    ovf_next       = 1'b0;
                    fill_next      = '0;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            fill_reg      <= '0;
            idx_reg       <= '0;
            ovf_reg       <= 1'b0;
            end_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            idx_reg       <= idx_next;
            ovf_reg       <= ovf_next;
            end_reg       <= end_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_byte_reg <= out_byte_next;
        out_done_reg <= out_done_next;
        out_ovf_reg  <= out_ovf_next;
    end

    assign m_valid          = out_valid_reg;
    assign m_wire_byte      = out_byte_reg;
    assign m_name_done      = out_done_reg;
    assign m_label_overflow = out_ovf_reg;

endmodule

// ===== design/dns_name_label_encoder.sv =====
// DNS name label encoder, top level.
// Connects the front end, which classifies incoming characters into a short
// queue, to the back end, which builds the wire-format labels.
//
// Usage: the s_ channel takes one item per transfer, either a name character
// (s_kind = 0) or the end of a name (s_kind = 1). The m_ channel gives the
// wire-format bytes: a length byte and the label bytes for each non-empty
// label, then a zero byte with m_name_done set. m_label_overflow is set on
// every byte sent after a label of the current name ran past LABEL_MAX
// characters; the excess characters are dropped.
// A character is taken by the back end and leaves nothing behind on the
// output. A dot is taken and then sends a length byte and the n bytes of the
// label, one byte per cycle from the label RAM while the receiver accepts
// them. An end of name adds the terminator byte. The back end takes no new
// command while it sends; the two-entry queue keeps s_ready high while a
// label burst is in progress, until it fills.
// Reset clears the queue, the label length and the overflow flag; no clearing
// pass of the label RAM is needed. When the receiver stalls, the output
// register holds its byte, the back end waits, and the queue fills up before
// s_ready drops.
module dns_name_label_encoder
    import dnle_pkg::*;
#(
    parameter int LABEL_MAX = LABEL_MAX_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic       s_kind,
    input  logic [7:0] s_character,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_wire_byte,
    output logic       m_name_done,
    output logic       m_label_overflow
);

    logic cmd_valid;
    logic cmd_ready;
    cmd_t cmd;

    dnle_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_kind      (s_kind),
        .s_character (s_character),
        .cmd_valid   (cmd_valid),
        .cmd_ready   (cmd_ready),
        .cmd         (cmd)
    );

    dnle_back #(
        .LABEL_MAX (LABEL_MAX)
    ) u_back (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cmd_valid        (cmd_valid),
        .cmd_ready        (cmd_ready),
        .cmd              (cmd),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_wire_byte      (m_wire_byte),
        .m_name_done      (m_name_done),
        .m_label_overflow (m_label_overflow)
    );

    a_done_is_terminator: assert property (
        @(posedge aclk) disable iff (!aresetn)
        m_valid && m_name_done |-> m_wire_byte == TERMINATOR
    ) else $error("name_done set on a byte other than the terminator");

    a_full_queue_has_cmd: assert property (
        @(posedge aclk) disable iff (!aresetn)
        !s_ready |-> cmd_valid
    ) else $error("input stalled while the queue offers no command");

    a_cmd_held_when_busy: assert property (
        @(posedge aclk) disable iff (!aresetn)
        cmd_valid && !cmd_ready |=> cmd_valid && $stable(cmd)
    ) else $error("queued command changed before the back end took it");

endmodule

// ===== sim/dns_name_label_encoder_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for dns_name_label_encoder: it streams dotted names, predicts the
// wire-format bytes and compares each output transfer with that prediction.
// Depends on dnle_pkg and the dns_name_label_encoder RTL.
module dns_name_label_encoder_tb;
    import dnle_pkg::*;

    localparam int LABEL_LIMIT = LABEL_MAX_DEF;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int TAIL_CYCLES = 20;

    typedef struct packed {
        logic [7:0] wire_byte;
        logic       name_done;
        logic       label_overflow;
    } wire_out_t;

    logic       aclk;
    logic       aresetn;
    logic       s_valid;
    logic       s_ready;
    logic       s_kind;
    logic [7:0] s_character;
    logic       m_valid;
    logic       m_ready;
    logic [7:0] m_wire_byte;
    logic       m_name_done;
    logic       m_label_overflow;

    wire_out_t   expected_bytes[$];
    logic [7:0]  pending_label [LABEL_LIMIT];
    int unsigned pending_len = 0;
    logic        truncated = 1'b0;
    int          error_count = 0;
    int          items_sent = 0;
    int          cycle_count = 0;
    int          ready_hold = 0;
    bit          idle_on;

    dns_name_label_encoder u_dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_kind           (s_kind),
        .s_character      (s_character),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_wire_byte      (m_wire_byte),
        .m_name_done      (m_name_done),
        .m_label_overflow (m_label_overflow)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    function automatic void push_wire_byte(logic [7:0] value, logic done);
        wire_out_t rec;
        rec.wire_byte      = value;
        rec.name_done      = done;
        rec.label_overflow = truncated;
        expected_bytes.push_back(rec);
    endfunction

    function automatic void flush_pending_label();
        if (pending_len != 0) begin
            push_wire_byte(8'(pending_len), 1'b0);
            for (int i = 0; i < pending_len; i++) begin
                push_wire_byte(pending_label[i], 1'b0);
            end
            pending_len = 0;
        end
    endfunction

    function automatic void encode_item(logic kind, logic [7:0] ch);
        logic [7:0] folded;
        folded = ch;
        if (kind == KIND_END) begin
            flush_pending_label();
            push_wire_byte(TERMINATOR, 1'b1);
            truncated = 1'b0;
        end else if (ch == CH_DOT) begin
            flush_pending_label();
        end else begin
            if (ch >= CH_UPPER_A && ch <= CH_UPPER_Z) begin
                folded = ch + CASE_OFFSET;
            end
            if (pending_len < LABEL_LIMIT) begin
                pending_label[pending_len] = folded;
                pending_len++;
            end else begin
                truncated = 1'b1;
            end
        end
    endfunction

    always @(posedge aclk) begin
        wire_out_t want;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                encode_item(s_kind, s_character);
            end
            if (m_valid && m_ready) begin
                if (expected_bytes.size() == 0) begin
                    $error("unexpected output transfer: wire_byte %0h", m_wire_byte);
                    error_count++;
                end else begin
                    want = expected_bytes.pop_front();
                    if (m_wire_byte !== want.wire_byte) begin
                        $error("wire_byte: expected %0h, actual %0h",
                               want.wire_byte, m_wire_byte);
                        error_count++;
                    end
                    if (m_name_done !== want.name_done) begin
                        $error("name_done: expected %0b, actual %0b",
                               want.name_done, m_name_done);
                        error_count++;
                    end
                    if (m_label_overflow !== want.label_overflow) begin
                        $error("label_overflow: expected %0b, actual %0b",
                               want.label_overflow, m_label_overflow);
                        error_count++;
                    end
                end
            end
        end
    end

    always @(negedge aclk) begin
        if (ready_hold > 0) begin
            ready_hold <= ready_hold - 1;
            m_ready    <= 1'b0;
        end else if (idle_on && $urandom_range(0, 7) == 0) begin
            ready_hold <= $urandom_range(0, 4);
            m_ready    <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    task automatic send_item(logic kind, logic [7:0] ch);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            @(negedge aclk);
            s_valid <= 1'b0;
            repeat ($urandom_range(0, 4)) @(negedge aclk);
        end
        @(negedge aclk);
        s_valid     <= 1'b1;
        s_kind      <= kind;
        s_character <= ch;
        do @(posedge aclk); while (!s_ready);
        items_sent++;
    endtask

    task automatic wait_for_results();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (expected_bytes.size() != 0) @(posedge aclk);
    endtask

    task automatic send_text(string txt);
        for (int i = 0; i < txt.len(); i++) begin
            send_item(KIND_CHAR, txt[i]);
        end
    endtask

    function automatic logic [7:0] label_char();
        logic [7:0] c;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: c = 8'($urandom_range(8'h61, 8'h7A));
            4, 5:       c = 8'($urandom_range(CH_UPPER_A, CH_UPPER_Z));
            6:          c = 8'($urandom_range(8'h30, 8'h39));
            7:          c = 8'h2D;
            default: begin
                c = 8'($urandom_range(0, 255));
                if (c == CH_DOT) c = 8'h5F;
            end
        endcase
        return c;
    endfunction

    task automatic send_label(int len);
        for (int i = 0; i < len; i++) begin
            send_item(KIND_CHAR, label_char());
        end
    endtask

    task automatic send_random_name();
        int labels;
        labels = $urandom_range(0, 4);
        if ($urandom_range(0, 9) == 0) send_item(KIND_CHAR, CH_DOT);
        for (int l = 0; l < labels; l++) begin
            if (l > 0) begin
                send_item(KIND_CHAR, CH_DOT);
                if ($urandom_range(0, 11) == 0) send_item(KIND_CHAR, CH_DOT);
            end
            if ($urandom_range(0, 24) == 0) begin
                send_label($urandom_range(LABEL_LIMIT - 3, LABEL_LIMIT + 8));
            end else begin
                send_label($urandom_range(1, 10));
            end
        end
        if ($urandom_range(0, 4) == 0) send_item(KIND_CHAR, CH_DOT);
        send_item(KIND_END, 8'($urandom()));
    endtask

    task automatic send_noise(int count);
        logic [7:0] c;
        for (int i = 0; i < count; i++) begin
            c = ($urandom_range(0, 4) == 0) ? CH_DOT : 8'($urandom_range(0, 255));
            send_item(($urandom_range(0, 5) == 0) ? KIND_END : KIND_CHAR, c);
        end
    endtask

    // Letters at and just past both ends of the upper-case range, and an end of name
    // whose character field holds a dot that must be ignored.
    task automatic test_case_folding();
        idle_on = 1'b0;
        send_text("@AZ[.`az{");
        send_item(KIND_END, CH_DOT);
        wait_for_results();
    endtask

    task automatic test_empty_labels();
        idle_on = 1'b1;
        send_item(KIND_CHAR, CH_DOT);
        send_item(KIND_END, 8'hFF);
        send_item(KIND_END, 8'h00);
        send_item(KIND_CHAR, CH_DOT);
        send_item(KIND_CHAR, CH_DOT);
        send_item(KIND_CHAR, 8'h00);
        send_item(KIND_CHAR, 8'hFF);
        send_item(KIND_CHAR, CH_DOT);
        send_item(KIND_CHAR, CH_DOT);
        send_item(KIND_END, 8'h00);
        wait_for_results();
    endtask

    // A full label, then truncated ones; the overflow flag must stay set for the
    // rest of the name and be clear again on the next name.
    task automatic test_long_labels();
        idle_on = 1'b1;
        send_label(LABEL_LIMIT);
        send_item(KIND_CHAR, CH_DOT);
        send_label(LABEL_LIMIT + 1);
        send_item(KIND_CHAR, CH_DOT);
        send_text("Ok");
        send_item(KIND_END, 8'hA5);
        send_label(LABEL_LIMIT + 6);
        send_item(KIND_END, 8'h5A);
        send_text("after");
        send_item(KIND_END, 8'h00);
        wait_for_results();
    endtask

    task automatic test_random_names(int target, bit allow_idle);
        int goal;
        goal = items_sent + target;
        while (items_sent < goal) begin
            idle_on = allow_idle && ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 6) == 0) begin
                send_noise($urandom_range(1, 8));
            end else begin
                send_random_name();
            end
        end
    endtask

    initial begin
        s_valid     = 1'b0;
        s_kind      = KIND_CHAR;
        s_character = 8'h00;
        m_ready     = 1'b0;
        idle_on     = 1'b0;
        aresetn     = 1'b0;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_case_folding();
        test_empty_labels();
        test_long_labels();
        test_random_names(180, 1'b1);
        test_random_names(45, 1'b0);

        wait_for_results();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (error_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
design/dnle_pkg.sv
design/dnle_ram.sv
design/dnle_front.sv
design/dnle_back.sv
design/dns_name_label_encoder.sv
sim/dns_name_label_encoder_tb.sv
